// ===== design/mexp_pkg.sv =====
// Shared constants and types for the modular exponentiation block.
// No dependencies; imported by every module of the block.
package mexp_pkg;

  // Port width of the data fields and default datapath width
  localparam int FIELD_W   = 32;
  localparam int DEF_WIDTH = 32;

  // Reset contents of the configuration registers
  localparam logic [FIELD_W-1:0] MODULUS_RESET = 32'd14;
  localparam logic [FIELD_W-1:0] PRIV_EXP_RESET = 32'd11;

  // Configuration register map
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULUS  = 1'b0,
    CFG_PRIV_EXP = 1'b1
  } cfg_index_t;

  // Request kinds
  localparam logic REQ_ENCRYPT = 1'b0;
  localparam logic REQ_DECRYPT = 1'b1;

  // Exponentiation sequencer states
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_REDUCE = 4'b0010,
    ST_SQUARE = 4'b0100,
    ST_MULT   = 4'b1000
  } state_t;

endpackage

// ===== design/mexp_mulmod.sv =====
// Bit-serial modular multiplier: p = (a * b) mod n, one bit of b per cycle.
// Depends on mexp_pkg for the default width. Requires a < n and n >= 2.
module mexp_mulmod import mexp_pkg::*; #(
  parameter int W = DEF_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] n,
  output logic         done,
  output logic [W-1:0] p
);

  localparam int CW = $clog2(W + 1);
  localparam int TW = W + 2;

  logic          running;
  logic [CW-1:0] cnt;
  logic [W-1:0]  acc;
  logic [W-1:0]  acc_next;
  logic [W-1:0]  a_r;
  logic [W-1:0]  bsh;
  logic [TW-1:0] t;
  logic [TW-1:0] n1;
  logic [TW-1:0] n2;

  // Double the accumulator, add a when the bit is set, fold back below n
  always_comb begin
    n1 = {2'b00, n};
    n2 = {1'b0, n, 1'b0};
    t  = {1'b0, acc, 1'b0} + (bsh[W-1] ? {2'b00, a_r} : {TW{1'b0}});
    if (t >= n2) begin
      acc_next = W'(t - n2);
    end else if (t >= n1) begin
      acc_next = W'(t - n1);
    end else begin
      acc_next = W'(t);
    end
  end

  // Sequence the bit count and flag completion
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CW'(W);
      end else if (running) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Load operands, then shift the multiplier bits out top first
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      a_r <= a;
      bsh <= b;
    end else if (running) begin
      acc <= acc_next;
      bsh <= {bsh[W-2:0], 1'b0};
    end
  end

  assign p = acc;

  // A new operation never lands on one in flight
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !running)
    else $error("multiplier started while running");
  // Completion is flagged only as the last bit retires
  a_done_end: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(running) && !running)
    else $error("multiplier done without a finishing step");

endmodule

// ===== design/mexp_engine.sv =====
// Square-and-multiply sequencer: reduces the base, then scans the exponent.
// Depends on mexp_pkg and drives one shared mexp_mulmod.
module mexp_engine import mexp_pkg::*; #(
  parameter int W = DEF_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] msg,
  input  logic [W-1:0] ex,
  input  logic [W-1:0] n,
  output logic         done,
  output logic [W-1:0] res
);

  localparam int KW = $clog2(W + 1);

  state_t        state;
  logic          mul_go;
  logic [W-1:0]  mul_a;
  logic [W-1:0]  mul_b;
  logic          mul_done;
  logic [W-1:0]  mul_p;
  logic [W-1:0]  base;
  logic [W-1:0]  exs;
  logic [KW-1:0] k;

  mexp_mulmod #(.W(W)) u_mulmod (
    .clk   (clk),
    .rst   (rst),
    .start (mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .n     (n),
    .done  (mul_done),
    .p     (mul_p)
  );

  // Walk reduce, then square and optional multiply per exponent bit; n < 2 gives 0
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      mul_go <= 1'b0;
      done   <= 1'b0;
    end else begin
      mul_go <= 1'b0;
      done   <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            exs <= ex;
            k   <= KW'(W);
            if (n < W'(2)) begin
              res  <= '0;
              done <= 1'b1;
            end else begin
              // base mod n as 1 * msg mod n
              mul_a  <= W'(1);
              mul_b  <= msg;
              mul_go <= 1'b1;
              state  <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          if (mul_done) begin
            base   <= mul_p;
            mul_a  <= W'(1);
            mul_b  <= W'(1);
            mul_go <= 1'b1;
            state  <= ST_SQUARE;
          end
        end
        ST_SQUARE, ST_MULT: begin
          if (mul_done) begin
            if (state == ST_SQUARE && exs[W-1]) begin
              mul_a  <= mul_p;
              mul_b  <= base;
              mul_go <= 1'b1;
              state  <= ST_MULT;
            end else begin
              // advance to the next exponent bit
              exs <= {exs[W-2:0], 1'b0};
              k   <= k - KW'(1);
              if (k == KW'(1)) begin
                res   <= mul_p;
                done  <= 1'b1;
                state <= ST_IDLE;
              end else begin
                mul_a  <= mul_p;
                mul_b  <= mul_p;
                mul_go <= 1'b1;
                state  <= ST_SQUARE;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Multiplier launches only from a working state
  a_go_busy: assert property (@(posedge clk) disable iff (rst)
    mul_go |-> state != ST_IDLE)
    else $error("multiply launched while idle");

endmodule

// ===== design/modular_exponentiation.sv =====
// Top level of the modular exponentiation block: config registers, request
// capture and the output word register. Depends on mexp_pkg, mexp_engine.
//
// Computes message^e mod modulus, with e the request's public_exponent for an
// encrypt word and the private_exponent register for a decrypt word; a zero
// exponent gives 1 and a modulus below 2 gives 0. One request is in work at a
// time. All arithmetic runs through one bit-serial modular multiplier; a
// request needs one product to reduce the message plus one square per
// exponent bit and one multiply per set bit. A modulus below 2 skips the
// multiplier, and its word goes from the engine's result register through
// the pending flag into the output register. A finished word waits in an
// output register, and the next request is taken once the previous result
// has moved there. Write configuration only while idle.
module modular_exponentiation import mexp_pkg::*; #(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  // request channel
  input  logic                 req_valid,
  output logic                 req_ready,
  input  logic                 req_type,
  input  logic [FIELD_W-1:0]   message,
  input  logic [FIELD_W-1:0]   public_exponent,
  // result channel
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [FIELD_W-1:0]   result,
  // configuration channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_data
);

  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] private_exponent;
  logic             busy;
  logic             pend;
  logic             accept;
  logic [WIDTH-1:0] ex_sel;
  logic             eng_done;
  logic [WIDTH-1:0] eng_res;

  assign cfg_ready = 1'b1;
  assign req_ready = !busy;
  assign accept    = req_valid && req_ready;
  assign ex_sel    = (req_type == REQ_DECRYPT) ? private_exponent : WIDTH'(public_exponent);

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus          <= WIDTH'(MODULUS_RESET);
      private_exponent <= WIDTH'(PRIV_EXP_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODULUS:  modulus          <= WIDTH'(cfg_data);
        CFG_PRIV_EXP: private_exponent <= WIDTH'(cfg_data);
        default: ;
      endcase
    end
  end

  mexp_engine #(.W(WIDTH)) u_engine (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .msg   (WIDTH'(message)),
    .ex    (ex_sel),
    .n     (modulus),
    .done  (eng_done),
    .res   (eng_res)
  );

  // Track the request in work and move its word into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end
      if (eng_done) begin
        pend <= 1'b1;
      end
      if (pend && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
        pend         <= 1'b0;
        busy         <= 1'b0;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Load the output word
  always_ff @(posedge clk) begin
    if (pend && (!result_valid || result_ready)) begin
      result <= FIELD_W'(eng_res);
    end
  end

  // The engine finishes only work that was accepted
  a_done_busy: assert property (@(posedge clk) disable iff (rst) eng_done |-> busy && !pend)
    else $error("engine finished with no request in work");
  // An accepted request keeps the input side closed
  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("request accepted but block not busy");
  // A waiting word always belongs to a request in work
  a_pend_busy: assert property (@(posedge clk) disable iff (rst) pend |-> busy)
    else $error("pending word with block idle");

endmodule
